// File: hw/rtl/lidar_bev_height_raster_defines.svh
// assertion macros for the height raster
`ifndef LIDAR_BEV_HEIGHT_RASTER_DEFINES_SVH
`define LIDAR_BEV_HEIGHT_RASTER_DEFINES_SVH

`define LBHR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbhr check failed");

`define LBHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbhr check failed");

`endif

// File: hw/rtl/lbhr_pkg.sv
`timescale 1ns / 1ps
package lbhr_pkg;

  typedef struct packed {
    logic        req_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [9:0]  read_col;
    logic [9:0]  read_row;
  } in_word_t;

  typedef struct packed {
    logic       kept;
    logic [9:0] pix_col;
    logic [9:0] pix_row;
    logic [7:0] gray;
    logic       occupied;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_CHECK, ST_DIV_XH, ST_DIV_PX, ST_DIV_YH, ST_DIV_PY,
    ST_MAP, ST_RD_ADDR, ST_RD_WAIT, ST_RD_EVAL, ST_DIV_G, ST_DONE
  } state_t;

  localparam logic [2:0] REG_X_LOW  = 3'd0;
  localparam logic [2:0] REG_X_HIGH = 3'd1;
  localparam logic [2:0] REG_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_Z_LOW  = 3'd4;
  localparam logic [2:0] REG_Z_HIGH = 3'd5;
  localparam logic [2:0] REG_CELL   = 3'd6;

  localparam logic       REQ_ADD  = 1'b0;
  localparam logic       REQ_READ = 1'b1;

  localparam int DIV_W = 25;

endpackage

// File: hw/rtl/lidar_bev_height_raster.sv
`timescale 1ns / 1ps
// one word at a time: an in-range add runs four divisions on the shared restoring divider,
// a rejected add none, and a read one only to scale the gray value of an occupied cell
// the next word is taken at the earliest at the edge that ends the result strobe
// after reset a clearing pass over all GRID_COLS*GRID_ROWS cells empties the occupancy memory;
// busy stays high during it and no word is taken
// results appear for one cycle on out_valid; the receiver cannot stall
module lidar_bev_height_raster #(
  parameter int GRID_COLS = 1024,
  parameter int GRID_ROWS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lbhr_pkg::in_word_t  in_word,
  output logic                out_valid,
  output lbhr_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int CB   = $clog2(GRID_COLS);
  localparam int RB   = $clog2(GRID_ROWS);
  localparam int NPIX = GRID_COLS * GRID_ROWS;
  localparam int AW   = $clog2(NPIX);
  localparam int W    = lbhr_pkg::DIV_W;

  logic signed [15:0] x_low_r, x_high_r, y_low_r, y_high_r, z_low_r, z_high_r;
  logic [14:0] cell_r;

  lbhr_pkg::state_t state_r, state_nxt;
  lbhr_pkg::in_word_t req_r;
  lbhr_pkg::out_word_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic signed [16:0] q_xh_r, q_xh_nxt, q_px_r, q_px_nxt, q_yh_r, q_yh_nxt;
  logic signed [16:0] q_py_r, q_py_nxt;
  logic signed [15:0] hmin_r, hmin_nxt, hmax_r, hmax_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic        neg_r, neg_nxt;

  logic [15:0] height_mem [NPIX];
  logic        valid_mem  [NPIX];
  logic [15:0] rd_h_r;
  logic        rd_v_r;
  logic        mem_we, mem_ve;
  logic [AW-1:0] mem_addr;
  logic          mem_vbit;

  logic          div_go, div_done;
  logic [W-1:0]  div_a, div_b, div_q;

  logic [15:0]        cs_eff;
  logic signed [16:0] div_num;
  logic               num_neg;
  logic [16:0]        num_abs;
  logic signed [17:0] col_s, row_s;
  logic               in_range, in_grid;
  logic signed [17:0] span, diff;

  lbhr_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  assign cs_eff = (cell_r == '0) ? 16'd1 : {1'b0, cell_r};
  assign col_s  = 18'(q_xh_r) + 18'(q_px_r);
  assign row_s  = 18'(q_yh_r) - 18'(q_py_r);
  assign in_grid = (col_s >= 0) && (col_s < 18'(GRID_COLS)) &&
                   (row_s >= 0) && (row_s < 18'(GRID_ROWS));
  assign in_range = ($signed(req_r.pos_x) > x_low_r) && ($signed(req_r.pos_x) < x_high_r) &&
                    ($signed(req_r.pos_y) > y_low_r) && ($signed(req_r.pos_y) < y_high_r) &&
                    ($signed(req_r.pos_z) > z_low_r) && ($signed(req_r.pos_z) < z_high_r);
  assign span = 18'(hmax_r) - 18'(hmin_r);
  assign diff = 18'($signed(rd_h_r)) - 18'(hmin_r);

  // dividend of the coordinate division that starts in this state
  always_comb begin
    case (state_r)
      lbhr_pkg::ST_CHECK:  div_num = 17'(x_high_r);
      lbhr_pkg::ST_DIV_XH: div_num = 17'($signed(req_r.pos_x));
      lbhr_pkg::ST_DIV_PX: div_num = 17'(y_high_r);
      lbhr_pkg::ST_DIV_YH: div_num = 17'($signed(req_r.pos_y));
      default:             div_num = '0;
    endcase
  end
  assign num_neg = div_num[16];
  assign num_abs = num_neg ? 17'(-div_num) : 17'(div_num);
  assign neg_nxt = div_go ? num_neg : neg_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbhr_pkg::ST_CLEAR:   if (clr_r == (AW+1)'(NPIX - 1)) state_nxt = lbhr_pkg::ST_IDLE;
      lbhr_pkg::ST_IDLE:    if (start) state_nxt = (in_word.req_type == lbhr_pkg::REQ_ADD) ?
                                lbhr_pkg::ST_CHECK : lbhr_pkg::ST_RD_ADDR;
      lbhr_pkg::ST_CHECK:   state_nxt = in_range ? lbhr_pkg::ST_DIV_XH : lbhr_pkg::ST_DONE;
      lbhr_pkg::ST_DIV_XH:  if (div_done) state_nxt = lbhr_pkg::ST_DIV_PX;
      lbhr_pkg::ST_DIV_PX:  if (div_done) state_nxt = lbhr_pkg::ST_DIV_YH;
      lbhr_pkg::ST_DIV_YH:  if (div_done) state_nxt = lbhr_pkg::ST_DIV_PY;
      lbhr_pkg::ST_DIV_PY:  if (div_done) state_nxt = lbhr_pkg::ST_MAP;
      lbhr_pkg::ST_MAP:     state_nxt = lbhr_pkg::ST_DONE;
      lbhr_pkg::ST_RD_ADDR: state_nxt = lbhr_pkg::ST_RD_WAIT;
      lbhr_pkg::ST_RD_WAIT: state_nxt = lbhr_pkg::ST_RD_EVAL;
      lbhr_pkg::ST_RD_EVAL: state_nxt = (res_nxt.occupied && span > 0 && diff >= 0) ?
                                lbhr_pkg::ST_DIV_G : lbhr_pkg::ST_DONE;
      lbhr_pkg::ST_DIV_G:   if (div_done) state_nxt = lbhr_pkg::ST_DONE;
      lbhr_pkg::ST_DONE:    state_nxt = lbhr_pkg::ST_IDLE;
      default:              state_nxt = lbhr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    q_xh_nxt = q_xh_r;
    q_px_nxt = q_px_r;
    q_yh_nxt = q_yh_r;
    q_py_nxt = q_py_r;
    hmin_nxt = hmin_r;
    hmax_nxt = hmax_r;
    clr_nxt  = clr_r;
    mem_we   = 1'b0;
    mem_ve   = 1'b0;
    mem_vbit = 1'b0;
    mem_addr = AW'(req_r.read_row) * AW'(GRID_COLS) + AW'(req_r.read_col);
    div_go   = 1'b0;
    div_a    = W'(num_abs);
    div_b    = W'(cs_eff);
    case (state_r)
      lbhr_pkg::ST_CLEAR: begin
        mem_ve   = 1'b1;
        mem_addr = clr_r[AW-1:0];
        clr_nxt  = clr_r + 1'b1;
      end
      lbhr_pkg::ST_IDLE: res_nxt = '0;
      lbhr_pkg::ST_CHECK: div_go = in_range;
      lbhr_pkg::ST_DIV_XH, lbhr_pkg::ST_DIV_PX, lbhr_pkg::ST_DIV_YH,
      lbhr_pkg::ST_DIV_PY: begin
        if (div_done) begin
          if (state_r != lbhr_pkg::ST_DIV_PY) div_go = 1'b1;
          case (state_r)
            lbhr_pkg::ST_DIV_XH: q_xh_nxt = neg_r ? -17'(div_q) : 17'(div_q);
            lbhr_pkg::ST_DIV_PX: q_px_nxt = neg_r ? -17'(div_q) : 17'(div_q);
            lbhr_pkg::ST_DIV_YH: q_yh_nxt = neg_r ? -17'(div_q) : 17'(div_q);
            default:             q_py_nxt = neg_r ? -17'(div_q) : 17'(div_q);
          endcase
        end
      end
      lbhr_pkg::ST_MAP: begin
        if (in_grid) begin
          mem_addr = AW'(row_s[RB-1:0]) * AW'(GRID_COLS) + AW'(col_s[CB-1:0]);
          mem_we   = 1'b1;
          mem_ve   = 1'b1;
          mem_vbit = 1'b1;
          if ($signed(req_r.pos_z) < hmin_r) hmin_nxt = $signed(req_r.pos_z);
          if ($signed(req_r.pos_z) > hmax_r) hmax_nxt = $signed(req_r.pos_z);
          res_nxt.kept    = 1'b1;
          res_nxt.pix_col = col_s[9:0];
          res_nxt.pix_row = row_s[9:0];
        end
      end
      lbhr_pkg::ST_RD_EVAL: begin
        res_nxt.occupied = rd_v_r && (32'(req_r.read_col) < GRID_COLS) &&
                           (32'(req_r.read_row) < GRID_ROWS);
        div_a  = W'({diff[16:0], 8'h00});
        div_b  = W'(span[16:0]);
        div_go = res_nxt.occupied && span > 0 && diff >= 0;
      end
      lbhr_pkg::ST_DIV_G: begin
        if (div_done) res_nxt.gray = (div_q > W'(255)) ? 8'hff : div_q[7:0];
      end
      lbhr_pkg::ST_DONE: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) height_mem[mem_addr] <= req_r.pos_z;
    if (mem_ve) valid_mem[mem_addr] <= mem_vbit;
    rd_h_r <= height_mem[mem_addr];
    rd_v_r <= valid_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbhr_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      hmin_r      <= 16'sd32767;
      hmax_r      <= -16'sd32768;
      x_low_r  <= -16'sd20000;
      x_high_r <= 16'sd20000;
      y_low_r  <= -16'sd20000;
      y_high_r <= 16'sd20000;
      z_low_r  <= -16'sd1000;
      z_high_r <= 16'sd3000;
      cell_r   <= 15'd50;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      hmin_r      <= hmin_nxt;
      hmax_r      <= hmax_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbhr_pkg::REG_X_LOW:  x_low_r  <= cfg_data;
          lbhr_pkg::REG_X_HIGH: x_high_r <= cfg_data;
          lbhr_pkg::REG_Y_LOW:  y_low_r  <= cfg_data;
          lbhr_pkg::REG_Y_HIGH: y_high_r <= cfg_data;
          lbhr_pkg::REG_Z_LOW:  z_low_r  <= cfg_data;
          lbhr_pkg::REG_Z_HIGH: z_high_r <= cfg_data;
          lbhr_pkg::REG_CELL:   cell_r   <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
    if (state_r == lbhr_pkg::ST_IDLE && start) req_r <= in_word;
    res_r  <= res_nxt;
    neg_r  <= neg_nxt;
    q_xh_r <= q_xh_nxt;
    q_px_r <= q_px_nxt;
    q_yh_r <= q_yh_nxt;
    q_py_r <= q_py_nxt;
  end

  assign busy      = (state_r != lbhr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = res_r;

endmodule

// File: hw/rtl/lbhr_divider.sv
`timescale 1ns / 1ps
module lbhr_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [lbhr_pkg::DIV_W-1:0] dividend,
  input  logic [lbhr_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [lbhr_pkg::DIV_W-1:0] quotient
);

  localparam int W  = lbhr_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (go) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/lbhr_checker.sv
`timescale 1ns / 1ps
`include "lidar_bev_height_raster_defines.svh"
module lbhr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input lbhr_pkg::out_word_t out_word
);

  // an accepted word makes the block busy
  `LBHR_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  // a result only ends a busy spell
  `LBHR_ASSERT_IMPL(a_result_when_busy, clk, rst_n, out_valid, $past(busy))
  // no result reports a kept point together with occupancy
  `LBHR_ASSERT_IMPL(a_kinds_apart, clk, rst_n, out_valid, !(out_word.kept && out_word.occupied))
  // a strobe lasts one cycle
  `LBHR_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

endmodule

bind lidar_bev_height_raster lbhr_checker u_lbhr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);

// File: sim/lidar_bev_height_raster_tb.sv
`timescale 1ns / 1ps
module lidar_bev_height_raster_tb;

  localparam int COLS = 1024;
  localparam int ROWS = 1024;

  class raster_scoreboard;
    int xl, xh, yl, yh, zl, zh, cell_mm;
    logic [15:0] height_at [int];
    bit filled [int];
    int zmin, zmax;
    lbhr_pkg::out_word_t due [$];
    int hits [$];
    int errors;

    function new();
      xl = -20000; xh = 20000; yl = -20000; yh = 20000;
      zl = -1000; zh = 3000; cell_mm = 50;
      zmin = 32767; zmax = -32768;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        lbhr_pkg::REG_X_LOW:  xl = int'($signed(d));
        lbhr_pkg::REG_X_HIGH: xh = int'($signed(d));
        lbhr_pkg::REG_Y_LOW:  yl = int'($signed(d));
        lbhr_pkg::REG_Y_HIGH: yh = int'($signed(d));
        lbhr_pkg::REG_Z_LOW:  zl = int'($signed(d));
        lbhr_pkg::REG_Z_HIGH: zh = int'($signed(d));
        lbhr_pkg::REG_CELL:   cell_mm = int'(d[14:0]);
        default: ;
      endcase
    endfunction

    function void note(lbhr_pkg::in_word_t w);
      lbhr_pkg::out_word_t r;
      int px, py, pz, cs, col, row, key, hz;
      longint span, diff, g;
      r = '0;
      if (w.req_type == lbhr_pkg::REQ_ADD) begin
        px = int'($signed(w.pos_x));
        py = int'($signed(w.pos_y));
        pz = int'($signed(w.pos_z));
        cs = (cell_mm == 0) ? 1 : cell_mm;
        if (px > xl && px < xh && py > yl && py < yh && pz > zl && pz < zh) begin
          col = xh / cs + px / cs;
          row = yh / cs - py / cs;
          if (col >= 0 && col < COLS && row >= 0 && row < ROWS) begin
            key = row * COLS + col;
            height_at[key] = w.pos_z;
            if (!filled.exists(key)) hits = {hits, key};
            filled[key] = 1;
            if (pz < zmin) zmin = pz;
            if (pz > zmax) zmax = pz;
            r.kept = 1'b1;
            r.pix_col = col[9:0];
            r.pix_row = row[9:0];
          end
        end
      end else begin
        key = int'(w.read_row) * COLS + int'(w.read_col);
        if (filled.exists(key)) begin
          r.occupied = 1'b1;
          hz = int'($signed(height_at[key]));
          span = longint'(zmax) - longint'(zmin);
          diff = longint'(hz) - longint'(zmin);
          if (span > 0 && diff >= 0) begin
            g = (diff * 256) / span;
            r.gray = (g > 255) ? 8'd255 : g[7:0];
          end
        end
      end
      due = {due, r};
    endfunction

    function void check(lbhr_pkg::out_word_t a);
      lbhr_pkg::out_word_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", a);
        return;
      end
      e = due.pop_front();
      if (a.kept !== e.kept || a.pix_col !== e.pix_col || a.pix_row !== e.pix_row ||
          a.gray !== e.gray || a.occupied !== e.occupied) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kept %0d col %0d row %0d gray %0d occ %0d, %s",
                   e.kept, e.pix_col, e.pix_row, e.gray, e.occupied, "got");
        if (errors <= 10)
          $display("  got kept %0d col %0d row %0d gray %0d occ %0d",
                   a.kept, a.pix_col, a.pix_row, a.gray, a.occupied);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lbhr_pkg::in_word_t in_word = '0;
  logic out_valid;
  lbhr_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  raster_scoreboard sb = new();

  lidar_bev_height_raster dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_word);
  end

  task automatic send_word(lbhr_pkg::in_word_t w);
    int gap;
    gap = int'($urandom_range(16));
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val[15:0]);
  endtask

  task automatic configure(int xl, int xh, int yl, int yh, int zl, int zh, int c);
    drain();
    write_reg(lbhr_pkg::REG_X_LOW, xl);
    write_reg(lbhr_pkg::REG_X_HIGH, xh);
    write_reg(lbhr_pkg::REG_Y_LOW, yl);
    write_reg(lbhr_pkg::REG_Y_HIGH, yh);
    write_reg(lbhr_pkg::REG_Z_LOW, zl);
    write_reg(lbhr_pkg::REG_Z_HIGH, zh);
    write_reg(lbhr_pkg::REG_CELL, c);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_between(int lo, int hi);
    if (hi - lo < 2) return int'($signed(16'($urandom())));
    return lo + 1 + int'($urandom_range(hi - lo - 2));
  endfunction

  function automatic lbhr_pkg::in_word_t add_word(int x, int y, int z);
    lbhr_pkg::in_word_t w;
    w.read_col = 10'($urandom());
    w.read_row = 10'($urandom());
    w.req_type = lbhr_pkg::REQ_ADD;
    w.pos_x = x[15:0];
    w.pos_y = y[15:0];
    w.pos_z = z[15:0];
    return w;
  endfunction

  function automatic lbhr_pkg::in_word_t read_word(int col, int row);
    lbhr_pkg::in_word_t w;
    w.pos_x = 16'($urandom());
    w.pos_y = 16'($urandom());
    w.pos_z = 16'($urandom());
    w.req_type = lbhr_pkg::REQ_READ;
    w.read_col = col[9:0];
    w.read_row = row[9:0];
    return w;
  endfunction

  task automatic random_items(int n);
    int k, key;
    lbhr_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      k = int'($urandom_range(9));
      if (k < 5) begin
        w = add_word(pick_between(sb.xl, sb.xh), pick_between(sb.yl, sb.yh),
                     pick_between(sb.zl, sb.zh));
      end else if (k < 8 && sb.hits.size() > 0) begin
        key = sb.hits[$urandom_range(sb.hits.size() - 1)];
        w = read_word(key % COLS, key / COLS);
      end else if (k == 8) begin
        w = read_word(int'($urandom_range(1023)), int'($urandom_range(1023)));
      end else begin
        w = add_word(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))),
                     int'($signed(16'($urandom()))));
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset bounds: corners, open edges, flat span
    send_word(add_word(0, 0, 1000));
    send_word(read_word(400, 400));
    send_word(read_word(0, 0));
    send_word(add_word(19999, -19999, 2999));
    send_word(add_word(-19999, 19999, -999));
    send_word(add_word(20000, 0, 0));
    send_word(add_word(-20000, 0, 0));
    send_word(add_word(0, 20000, 0));
    send_word(add_word(0, -20000, 0));
    send_word(add_word(0, 0, 3000));
    send_word(add_word(0, 0, -1000));
    send_word(add_word(-32768, 32767, -32768));
    send_word(add_word(32767, -32768, 32767));
    send_word(read_word(799, 0));
    send_word(read_word(0, 799));
    send_word(read_word(400, 400));
    send_word(read_word(1023, 1023));
    random_items(100);

    // one mm cells, grid overflows on both sides
    configure(-700, 600, -600, 700, -32768, 32767, 1);
    send_word(add_word(-650, 0, -32767));
    send_word(add_word(599, 699, 32766));
    send_word(add_word(0, -599, 5));
    random_items(110);

    // widest bounds, biggest cell
    configure(-32768, 32767, -32768, 32767, -32768, 32767, 32767);
    send_word(add_word(-32767, 32766, 0));
    send_word(add_word(32766, -32767, 0));
    random_items(100);

    // zero cell acts as one
    configure(-300, 300, -300, 300, -100, 100, 0);
    random_items(100);

    // inverted and empty ranges
    configure(500, -500, 100, 101, 0, 0, 7);
    random_items(30);

    configure(-9000, 11000, -12000, 8000, -2000, 2500, 23);
    random_items(100);

    drain();
    if (sb.errors == 0) begin
      $display("lidar_bev_height_raster verification clean");
    end else begin
      $display("lidar_bev_height_raster verification failed");
    end
    $finish;
  end

  initial begin
    #120ms;
    $display("lidar_bev_height_raster verification failed");
    $finish;
  end
endmodule
